>>> rtl/assert_macros.svh
// Assertion helpers for the classifier checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SPCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("classifier check failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SPCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("classifier check failed");

`endif

>>> rtl/spcc_pkg.sv
// ----------------------------------------------------------------------------
// spcc_pkg
// Types and constants shared by the slab partition cell classifier.
// ----------------------------------------------------------------------------
`default_nettype none
package spcc_pkg;

  localparam logic [12:0] MAX_CELLS_PER_DIM = 13'd4096;
  localparam logic [10:0] MAX_PARTITIONS    = 11'd1024;

  localparam logic [2:0] CFG_SPLIT_AXIS = 3'd0;
  localparam logic [2:0] CFG_PART_COUNT = 3'd1;
  localparam logic [2:0] CFG_GHOST      = 3'd2;
  localparam logic [2:0] CFG_CELLS_I    = 3'd3;
  localparam logic [2:0] CFG_CELLS_J    = 3'd4;
  localparam logic [2:0] CFG_CELLS_K    = 3'd5;
  localparam logic [2:0] CFG_PERIODIC   = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CFG_BAD  = 2'd1;
  localparam logic [1:0] ST_PART_BAD = 2'd2;
  localparam logic [1:0] ST_CELL_BAD = 2'd3;

  localparam logic [1:0] AXIS_I = 2'd0;
  localparam logic [1:0] AXIS_J = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV1,
    S_RANGE1,
    S_RANGE2,
    S_GHOST,
    S_COUNT,
    S_DIV2,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_sel;     // 0: n / partition_count, 1: owner division
    logic save_base;
    logic calc_mul;
    logic calc_range;
    logic calc_ghost;
    logic calc_count;
    logic save_owner;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cfg_bad;
    logic part_bad;
    logic cell_bad;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

>>> rtl/spcc_div.sv
// ----------------------------------------------------------------------------
// spcc_div
// Restoring divider, 13-bit operands, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module spcc_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [12:0] dividend,
  input  wire logic [12:0] divisor,
  output logic             done,
  output logic [12:0]      quotient,
  output logic [12:0]      remainder
);

  logic [3:0]  cnt;
  logic [13:0] shifted;
  logic        fits;

  assign shifted = {remainder, quotient[12]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 4'd13;
      end else if (cnt != '0) begin
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
    end else if (cnt != '0) begin
      if (fits) begin
        remainder <= 13'(shifted - {1'b0, divisor});
      end else begin
        remainder <= shifted[12:0];
      end
      quotient <= {quotient[11:0], fits};
    end
  end

endmodule
`default_nettype wire

>>> rtl/spcc_datapath.sv
// ----------------------------------------------------------------------------
// spcc_datapath
// Configuration registers, slab arithmetic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module spcc_datapath
  import spcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic [11:0] cell_i,
  input  wire logic [11:0] cell_j,
  input  wire logic [11:0] cell_k,
  input  wire logic [9:0]  query_part,
  output logic [1:0]       status,
  output logic [9:0]       owner_part,
  output logic             is_owned,
  output logic             is_ghost,
  output logic             is_local,
  output logic [11:0]      range_begin,
  output logic [12:0]      range_end,
  output logic [36:0]      owned_count,
  output logic [36:0]      ghost_count
);

  logic [1:0]  split_axis;
  logic [10:0] partition_count;
  logic [11:0] ghost_depth;
  logic [12:0] cells_i, cells_j, cells_k;
  logic [2:0]  periodic_mask;

  logic [11:0] ci, cj, ck;
  logic [9:0]  q;
  logic [12:0] base, rem, qb, bigcells, b, e;
  logic [25:0] trans;
  logic [13:0] ghosts;
  logic        gflag;
  logic [36:0] own_cnt, gh_cnt;
  logic [9:0]  owner;

  logic [12:0] n, g, q13, coord13, big, width, b_calc, e_calc;
  logic [11:0] coord;
  logic        wrap, q_lt_rem, lo;
  logic [12:0] a0, a1;
  logic [25:0] trans_calc;
  logic [13:0] n14, b14, e14, c14, g14, m14, gw, d1, d2, gh_calc;
  logic        inr, gp;
  logic [38:0] own_prod, gh_prod;
  logic        div_done;
  logic [12:0] div_num, div_den, div_q, div_r;
  logic [1:0]  st_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_axis      <= 2'd0;
      partition_count <= 11'd1;
      ghost_depth     <= 12'd0;
      cells_i         <= 13'd1;
      cells_j         <= 13'd1;
      cells_k         <= 13'd1;
      periodic_mask   <= 3'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPLIT_AXIS: split_axis      <= cfg_data[1:0];
        CFG_PART_COUNT: partition_count <= cfg_data[10:0];
        CFG_GHOST:      ghost_depth     <= cfg_data[11:0];
        CFG_CELLS_I:    cells_i         <= cfg_data;
        CFG_CELLS_J:    cells_j         <= cfg_data;
        CFG_CELLS_K:    cells_k         <= cfg_data;
        CFG_PERIODIC:   periodic_mask   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (split_axis)
      AXIS_I: begin
        n = cells_i; coord = ci; a0 = cells_j; a1 = cells_k; wrap = periodic_mask[0];
      end
      AXIS_J: begin
        n = cells_j; coord = cj; a0 = cells_i; a1 = cells_k; wrap = periodic_mask[1];
      end
      default: begin
        n = cells_k; coord = ck; a0 = cells_i; a1 = cells_j; wrap = periodic_mask[2];
      end
    endcase
  end

  assign stat.cfg_bad = (split_axis == 2'd3)
      || (cells_i == '0) || (cells_i > MAX_CELLS_PER_DIM)
      || (cells_j == '0) || (cells_j > MAX_CELLS_PER_DIM)
      || (cells_k == '0) || (cells_k > MAX_CELLS_PER_DIM)
      || (partition_count == '0) || (partition_count > MAX_PARTITIONS)
      || ({2'b0, partition_count} > n);
  assign stat.part_bad = {1'b0, q} >= partition_count;
  assign stat.cell_bad = ({1'b0, ci} >= cells_i) || ({1'b0, cj} >= cells_j)
      || ({1'b0, ck} >= cells_k);
  assign stat.div_done = div_done;

  assign g        = ({1'b0, ghost_depth} < n) ? {1'b0, ghost_depth} : n;
  assign q13      = {3'b0, q};
  assign q_lt_rem = q13 < rem;
  assign big      = base + 13'd1;
  assign coord13  = {1'b0, coord};
  assign lo       = coord13 < bigcells;
  assign width    = e - b;

  assign trans_calc = {13'b0, a0} * {13'b0, a1};
  assign b_calc     = qb + (q_lt_rem ? q13 : rem);
  assign e_calc     = b_calc + base + {12'b0, q_lt_rem};

  // ghost planes: closed form over the non-owned arc
  assign n14 = {1'b0, n};
  assign b14 = {1'b0, b};
  assign e14 = {1'b0, e};
  assign c14 = {2'b0, coord};
  assign g14 = {1'b0, g};
  assign m14 = n14 - (e14 - b14);
  assign gw  = {g, 1'b0};
  always_comb begin
    if (wrap) begin
      gh_calc = (m14 < gw) ? m14 : gw;
    end else begin
      gh_calc = ((g14 < b14) ? g14 : b14) + ((g14 < n14 - e14) ? g14 : n14 - e14);
    end
  end

  assign inr = (c14 >= b14) && (c14 < e14);
  assign d1  = (c14 < b14) ? b14 - c14 : b14 + n14 - c14;
  assign d2  = (c14 >= e14) ? c14 - e14 + 14'd1 : c14 + n14 - e14 + 14'd1;
  always_comb begin
    if (wrap) begin
      gp = (d1 <= g14) || (d2 <= g14);
    end else begin
      gp = ((c14 < b14) && (b14 - c14 <= g14)) || ((c14 >= e14) && (c14 - e14 < g14));
    end
  end

  assign own_prod = {26'b0, width} * {13'b0, trans};
  assign gh_prod  = {25'b0, ghosts} * {13'b0, trans};

  assign div_num = cmd.div_sel ? (lo ? coord13 : coord13 - bigcells) : n;
  assign div_den = cmd.div_sel ? (lo ? big : base) : {2'b0, partition_count};

  spcc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ci <= cell_i;
      cj <= cell_j;
      ck <= cell_k;
      q  <= query_part;
    end
    if (cmd.save_base) begin
      base <= div_q;
      rem  <= div_r;
    end
    if (cmd.calc_mul) begin
      qb       <= 13'(q13 * base);
      trans    <= trans_calc;
      bigcells <= 13'(rem * big);
    end
    if (cmd.calc_range) begin
      b <= b_calc;
      e <= e_calc;
    end
    if (cmd.calc_ghost) begin
      ghosts <= gh_calc;
      gflag  <= !inr && (g != '0) && gp;
    end
    if (cmd.calc_count) begin
      own_cnt <= own_prod[36:0];
      gh_cnt  <= gh_prod[36:0];
    end
    if (cmd.save_owner) begin
      owner <= lo ? div_q[9:0] : rem[9:0] + div_q[9:0];
    end
  end

  always_comb begin
    if (stat.cfg_bad) begin
      st_code = ST_CFG_BAD;
    end else if (stat.part_bad) begin
      st_code = ST_PART_BAD;
    end else if (stat.cell_bad) begin
      st_code = ST_CELL_BAD;
    end else begin
      st_code = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status      <= st_code;
      owner_part  <= '0;
      is_owned    <= 1'b0;
      is_ghost    <= 1'b0;
      is_local    <= 1'b0;
      range_begin <= '0;
      range_end   <= '0;
      owned_count <= '0;
      ghost_count <= '0;
      if (st_code == ST_OK || st_code == ST_CELL_BAD) begin
        range_begin <= b[11:0];
        range_end   <= e;
        owned_count <= own_cnt;
        ghost_count <= gh_cnt;
      end
      if (st_code == ST_OK) begin
        owner_part <= owner;
        is_owned   <= owner == q;
        is_ghost   <= (owner != q) && gflag;
        is_local   <= (owner == q) || gflag;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/spcc_ctrl.sv
// ----------------------------------------------------------------------------
// spcc_ctrl
// Sequencer for one query and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module spcc_ctrl
  import spcc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.cfg_bad || stat.part_bad) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV1;
        end
      end
      S_DIV1: begin
        if (stat.div_done) begin
          cmd.save_base = 1'b1;
          state_next    = S_RANGE1;
        end
      end
      S_RANGE1: begin
        cmd.calc_mul = 1'b1;
        state_next   = S_RANGE2;
      end
      S_RANGE2: begin
        cmd.calc_range = 1'b1;
        state_next     = S_GHOST;
      end
      S_GHOST: begin
        cmd.calc_ghost = 1'b1;
        state_next     = S_COUNT;
      end
      S_COUNT: begin
        cmd.calc_count = 1'b1;
        if (stat.cell_bad) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_next    = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd.div_sel = 1'b1;
        if (stat.div_done) begin
          cmd.save_owner = 1'b1;
          state_next     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/slab_partition_cell_classifier.sv
// Sequence: a bad configuration or partition goes to the result without the divider;
// a cell out of range takes one pass of the shared restoring divider, a valid cell two.
// Flow: one query in flight; the next is taken once the result is registered, so a
// waiting result does not block the input.
// Reset: rst (synchronous) restores the register defaults and empties the block.
// ----------------------------------------------------------------------------
// slab_partition_cell_classifier
// Balanced slab split of a 3-D grid with ghost layers; classifies one cell.
// ----------------------------------------------------------------------------
`default_nettype none
module slab_partition_cell_classifier
  import spcc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] cell_i,
  input  wire logic [11:0] cell_j,
  input  wire logic [11:0] cell_k,
  input  wire logic [9:0]  query_part,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [9:0]       owner_part,
  output logic             is_owned,
  output logic             is_ghost,
  output logic             is_local,
  output logic [11:0]      range_begin,
  output logic [12:0]      range_end,
  output logic [36:0]      owned_count,
  output logic [36:0]      ghost_count
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  spcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spcc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cell_i      (cell_i),
    .cell_j      (cell_j),
    .cell_k      (cell_k),
    .query_part  (query_part),
    .status      (status),
    .owner_part  (owner_part),
    .is_owned    (is_owned),
    .is_ghost    (is_ghost),
    .is_local    (is_local),
    .range_begin (range_begin),
    .range_end   (range_end),
    .owned_count (owned_count),
    .ghost_count (ghost_count)
  );

endmodule
`default_nettype wire

>>> rtl/spcc_checker.sv
// ----------------------------------------------------------------------------
// spcc_checker
// Port-level checks on the classifier results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module spcc_checker
  import spcc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [9:0]  owner_part,
  input wire logic        is_owned,
  input wire logic        is_ghost,
  input wire logic        is_local,
  input wire logic [11:0] range_begin,
  input wire logic [12:0] range_end,
  input wire logic [36:0] owned_count
);

  `SPCC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))
  `SPCC_ASSERT_NOW(a_local, out_valid, is_local == (is_owned || is_ghost))
  `SPCC_ASSERT_NOW(a_flags_zero, out_valid && (status != ST_OK), !is_local && owner_part == '0)
  `SPCC_ASSERT_NOW(a_range, out_valid && (status == ST_OK || status == ST_CELL_BAD), {1'b0, range_begin} < range_end && owned_count != '0)

endmodule

bind slab_partition_cell_classifier spcc_checker u_chk (.*);
`default_nettype wire
